[design/wavetable_loop_player_macros.svh]
// ----------------------------------------------------------------------------
// Wavetable loop player assertion macros
// Shared concurrent check forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_LOOP_PLAYER_MACROS_SVH
`define WAVETABLE_LOOP_PLAYER_MACROS_SVH

// Same-cycle implication.
`define WTLP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WTLP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/wtlp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable loop player package
// Widths, codes, register map, control word and microcode program.
// ----------------------------------------------------------------------------
package wtlp_pkg;

	localparam int ADDR_BITS  = 16;
	localparam int FRAC_BITS  = 16;
	localparam int IDX_BITS   = 17;
	localparam int PH_BITS    = IDX_BITS + FRAC_BITS;
	localparam int WIDE_BITS  = PH_BITS + 4;
	localparam int SMP_BITS   = 16;
	localparam int INC_BITS   = 20;
	localparam int LEN_BITS   = 17;
	localparam int LS_BITS    = 16;
	localparam int GAIN_BITS  = 16;
	localparam int ENV_BITS   = 16;
	localparam int DIFF_BITS  = SMP_BITS + 1;
	localparam int MUL_B_BITS = DIFF_BITS;
	localparam int MUL_A_BITS = (SMP_BITS + GAIN_BITS + 1 > FRAC_BITS + 1) ?
		(SMP_BITS + GAIN_BITS + 1) : (FRAC_BITS + 1);
	localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
	localparam int IQ_BITS    = SMP_BITS + FRAC_BITS + 2;
	localparam int OUT_SHIFT  = 30;
	localparam int VAL_BITS   = MUL_P_BITS - OUT_SHIFT;
	localparam int PADDR_BITS = 5;
	localparam int REG_IDX_BITS = PADDR_BITS - 2;
	localparam int STEP_BITS  = 4;

	localparam logic [PH_BITS-1:0] PH_ONE = PH_BITS'(1) << FRAC_BITS;
	localparam logic [IQ_BITS-1:0] IQ_HALF = IQ_BITS'(1) << (FRAC_BITS - 1);
	localparam logic [MUL_P_BITS-1:0] OUT_ROUND = MUL_P_BITS'(1) << (OUT_SHIFT - 1);
	localparam logic signed [SMP_BITS-1:0] SMP_MAX = 16'sh7FFF;
	localparam logic signed [SMP_BITS-1:0] SMP_MIN = 16'sh8000;

	// Item modes
	localparam logic [1:0] MODE_LOAD     = 2'd0;
	localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
	localparam logic [1:0] MODE_NOTE_OFF = 2'd2;
	localparam logic [1:0] MODE_TICK     = 2'd3;

	// Loop modes
	localparam logic [1:0] LOOP_NONE     = 2'd0;
	localparam logic [1:0] LOOP_FORWARD  = 2'd1;
	localparam logic [1:0] LOOP_SUSTAIN  = 2'd2;
	localparam logic [1:0] LOOP_PINGPONG = 2'd3;

	// Register map
	localparam logic [REG_IDX_BITS-1:0] REG_PHASE_INC  = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_SAMPLE_LEN = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_LOOP_START = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_LOOP_END   = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_LOOP_MODE  = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_VOICE_GAIN = 3'd5;

	// Program addresses
	localparam logic [STEP_BITS-1:0] ST_LOAD     = 4'd0;
	localparam logic [STEP_BITS-1:0] ST_NOTE_ON  = 4'd1;
	localparam logic [STEP_BITS-1:0] ST_NOTE_OFF = 4'd2;
	localparam logic [STEP_BITS-1:0] ST_TICK0    = 4'd3;
	localparam logic [STEP_BITS-1:0] ST_TICK1    = 4'd4;
	localparam logic [STEP_BITS-1:0] ST_TICK2    = 4'd5;
	localparam logic [STEP_BITS-1:0] ST_TICK3    = 4'd6;
	localparam logic [STEP_BITS-1:0] ST_TICK4    = 4'd7;
	localparam logic [STEP_BITS-1:0] ST_TICK5    = 4'd8;
	localparam logic [STEP_BITS-1:0] ST_TICK6    = 4'd9;
	localparam logic [STEP_BITS-1:0] ST_TICK7    = 4'd10;
	localparam logic [STEP_BITS-1:0] ST_SKIP     = 4'd11;

	typedef enum logic [1:0] {
		MUL_NONE        = 2'd0,
		MUL_FRAC_DIFF   = 2'd1,
		MUL_INTERP_GAIN = 2'd2,
		MUL_PROD_ENV    = 2'd3
	} mul_op_t;

	typedef enum logic {
		COND_NEVER = 1'b0,
		COND_SKIP  = 1'b1
	} cond_t;

	typedef struct packed {
		logic [INC_BITS-1:0]  phase_increment;
		logic [LEN_BITS-1:0]  sample_length;
		logic [LS_BITS-1:0]   loop_start;
		logic [LEN_BITS-1:0]  loop_end;
		logic [1:0]           loop_mode;
		logic [GAIN_BITS-1:0] voice_gain;
	} cfg_t;

	typedef struct packed {
		logic                 mem_we;
		logic                 rd_lo;
		logic                 ph_sum;
		logic                 ph_lim;
		logic                 ph_cmp;
		logic                 ph_commit;
		logic                 cap_s1;
		logic                 cap_s0d;
		mul_op_t              mul;
		logic                 interp;
		logic                 emit;
		logic                 emit_zero;
		logic                 note_on;
		logic                 note_off;
		cond_t                cond;
		logic [STEP_BITS-1:0] target;
		logic                 done;
	} ctl_t;

	localparam ctl_t CTL_IDLE = '0;

	function automatic logic [STEP_BITS-1:0] entry_step(input logic [1:0] mode);
		logic [STEP_BITS-1:0] s;
		case (mode)
			MODE_LOAD:     s = ST_LOAD;
			MODE_NOTE_ON:  s = ST_NOTE_ON;
			MODE_NOTE_OFF: s = ST_NOTE_OFF;
			default:       s = ST_TICK0;
		endcase
		return s;
	endfunction

	// Microcode: one control word per step.
	function automatic ctl_t ucode(input logic [STEP_BITS-1:0] step);
		ctl_t c;
		c = CTL_IDLE;
		case (step)
			ST_LOAD: begin
				c.mem_we = 1'b1;
				c.done   = 1'b1;
			end
			ST_NOTE_ON: begin
				c.note_on = 1'b1;
				c.done    = 1'b1;
			end
			ST_NOTE_OFF: begin
				c.note_off = 1'b1;
				c.done     = 1'b1;
			end
			ST_TICK0: begin
				c.ph_sum = 1'b1;
				c.cond   = COND_SKIP;
				c.target = ST_SKIP;
			end
			ST_TICK1: begin
				c.rd_lo  = 1'b1;
				c.cap_s1 = 1'b1;
				c.ph_lim = 1'b1;
			end
			ST_TICK2: begin
				c.cap_s0d = 1'b1;
				c.ph_cmp  = 1'b1;
			end
			ST_TICK3: begin
				c.mul       = MUL_FRAC_DIFF;
				c.ph_commit = 1'b1;
			end
			ST_TICK4: c.interp = 1'b1;
			ST_TICK5: c.mul = MUL_INTERP_GAIN;
			ST_TICK6: c.mul = MUL_PROD_ENV;
			ST_TICK7: begin
				c.emit = 1'b1;
				c.done = 1'b1;
			end
			ST_SKIP: begin
				c.emit_zero = 1'b1;
				c.done      = 1'b1;
			end
			default: c.done = 1'b1;
		endcase
		return c;
	endfunction

endpackage

[design/wavetable_loop_player.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable loop player
// One sample-playback voice with linear interpolation, gain and envelope.
// ----------------------------------------------------------------------------
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-------------------------------
//  item in  | start && !busy                  | mode, load_address, load_data,
//           |                                 | sustain_held, envelope,
//           |                                 | envelope_idle
//  result   | result_valid (one-cycle strobe) | sample_out, voice_active
//  config   | psel && penable && pwrite       | paddr (4 bytes per register),
//           |                                 | pwdata; prdata on reads
//
//  Load, note-on and note-off items run a single program step; no new item
//  is taken while busy. A tick runs the eight steps ST_TICK0 to ST_TICK7,
//  set by the microcode program around the single RAM port (two reads) and
//  the one shared multiplier (three products). A tick on an idle voice or
//  past the sample end branches from ST_TICK0 to ST_SKIP and ends there.
//  The result strobe rises in the cycle after the program's last step.
//  Reset clears the voice and the registers; sample RAM holds no reset.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module wavetable_loop_player (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// item channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           mode,
	input  logic [15:0]                          load_address,
	input  logic signed [wtlp_pkg::SMP_BITS-1:0] load_data,
	input  logic                                 sustain_held,
	input  logic [wtlp_pkg::ENV_BITS-1:0]        envelope,
	input  logic                                 envelope_idle,
	// result channel
	output logic                                 result_valid,
	output logic signed [wtlp_pkg::SMP_BITS-1:0] sample_out,
	output logic                                 voice_active,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [wtlp_pkg::PADDR_BITS-1:0]      paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import wtlp_pkg::*;

	cfg_t cfg;
	ctl_t ctl;
	logic accept;
	logic tick_skip;

	// Take an item only while the sequencer is parked.
	assign accept = start && !busy;

	// Register file: the user must write it only while the voice is idle; the block itself does not enforce this.
	wtlp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Step through the microcode: dispatch on mode, branch out early on a
	// dead tick, drop busy on the last step.
	wtlp_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.tick_skip (tick_skip),
		.busy      (busy),
		.ctl       (ctl)
	);

	// Hold voice state, sample RAM and arithmetic; advance phase and emit
	// one result per tick under control of the current word.
	wtlp_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.load_address  (load_address),
		.load_data     (load_data),
		.sustain_held  (sustain_held),
		.envelope      (envelope),
		.envelope_idle (envelope_idle),
		.cfg           (cfg),
		.ctl           (ctl),
		.tick_skip     (tick_skip),
		.result_valid  (result_valid),
		.sample_out    (sample_out),
		.voice_active  (voice_active)
	);

endmodule

[design/wtlp_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable loop player configuration registers
// Register file behind a zero-wait-state APB-style port.
// ----------------------------------------------------------------------------
module wtlp_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wtlp_pkg::PADDR_BITS-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output wtlp_pkg::cfg_t                  cfg
);
	import wtlp_pkg::*;

	cfg_t                    cfg_q;
	logic                    wr_en;
	logic [REG_IDX_BITS-1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_BITS-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_increment <= INC_BITS'(65536);
			cfg_q.sample_length   <= LEN_BITS'(65536);
			cfg_q.loop_start      <= '0;
			cfg_q.loop_end        <= '0;
			cfg_q.loop_mode       <= LOOP_NONE;
			cfg_q.voice_gain      <= GAIN_BITS'(32768);
		end else if (wr_en) begin
			case (reg_idx)
				REG_PHASE_INC:  cfg_q.phase_increment <= pwdata[INC_BITS-1:0];
				REG_SAMPLE_LEN: cfg_q.sample_length   <= pwdata[LEN_BITS-1:0];
				REG_LOOP_START: cfg_q.loop_start      <= pwdata[LS_BITS-1:0];
				REG_LOOP_END:   cfg_q.loop_end        <= pwdata[LEN_BITS-1:0];
				REG_LOOP_MODE:  cfg_q.loop_mode       <= pwdata[1:0];
				REG_VOICE_GAIN: cfg_q.voice_gain      <= pwdata[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PHASE_INC:  prdata = 32'(cfg_q.phase_increment);
			REG_SAMPLE_LEN: prdata = 32'(cfg_q.sample_length);
			REG_LOOP_START: prdata = 32'(cfg_q.loop_start);
			REG_LOOP_END:   prdata = 32'(cfg_q.loop_end);
			REG_LOOP_MODE:  prdata = 32'(cfg_q.loop_mode);
			REG_VOICE_GAIN: prdata = 32'(cfg_q.voice_gain);
			default:        prdata = '0;
		endcase
	end

endmodule

[design/wtlp_sample_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable loop player sample RAM
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module wtlp_sample_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

endmodule

[design/wtlp_sequencer.sv]
`timescale 1ns / 1ps
`include "wavetable_loop_player_macros.svh"
// ----------------------------------------------------------------------------
// Wavetable loop player sequencer
// Step counter over the microcode program, dispatch by item mode.
// ----------------------------------------------------------------------------
module wtlp_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     mode,
	input  logic           tick_skip,
	output logic           busy,
	output wtlp_pkg::ctl_t ctl
);
	import wtlp_pkg::*;

	logic                 busy_q;
	logic [STEP_BITS-1:0] step_q;

	assign busy = busy_q;
	assign ctl  = busy_q ? ucode(step_q) : CTL_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_LOAD;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= entry_step(mode);
			end
		end else if (ctl.done) begin
			busy_q <= 1'b0;
		end else if (ctl.cond == COND_SKIP && tick_skip) begin
			step_q <= ctl.target;
		end else begin
			step_q <= step_q + STEP_BITS'(1);
		end
	end

	`WTLP_ASSERT_NXT(a_done_frees, busy_q && ctl.done, !busy_q, "sequencer stays busy after done")
	`WTLP_ASSERT_NXT(a_start_entry, start && !busy_q, busy_q && (step_q == ST_LOAD || step_q == ST_NOTE_ON || step_q == ST_NOTE_OFF || step_q == ST_TICK0), "bad entry step")

endmodule

[design/wtlp_datapath.sv]
`timescale 1ns / 1ps
`include "wavetable_loop_player_macros.svh"
// ----------------------------------------------------------------------------
// Wavetable loop player datapath
// Voice state, sample RAM, shared multiplier and phase arithmetic.
// ----------------------------------------------------------------------------
module wtlp_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic [15:0]                           load_address,
	input  logic signed [wtlp_pkg::SMP_BITS-1:0]  load_data,
	input  logic                                  sustain_held,
	input  logic [wtlp_pkg::ENV_BITS-1:0]         envelope,
	input  logic                                  envelope_idle,
	input  wtlp_pkg::cfg_t                        cfg,
	input  wtlp_pkg::ctl_t                        ctl,
	output logic                                  tick_skip,
	output logic                                  result_valid,
	output logic signed [wtlp_pkg::SMP_BITS-1:0]  sample_out,
	output logic                                  voice_active
);
	import wtlp_pkg::*;

	// item latches
	logic [15:0]                 load_address_q;
	logic signed [SMP_BITS-1:0]  load_data_q;
	logic                        sustain_q;
	logic [ENV_BITS-1:0]         envelope_q;
	logic                        env_idle_q;

	// voice state
	logic [PH_BITS-1:0] phase_q;
	logic               fwd_q;
	logic               key_q;
	logic               playing_q;
	logic [1:0]         alm_q;

	logic [IDX_BITS-1:0]  idx;
	logic [IDX_BITS-1:0]  idx_lo;
	logic [FRAC_BITS-1:0] frac;
	logic [ADDR_BITS-1:0] mem_addr;
	logic [SMP_BITS-1:0]  mem_rdata;

	// phase work registers
	logic signed [WIDE_BITS-1:0] ph_w, inc_w, ls_w, le_w, len_w;
	logic signed [WIDE_BITS-1:0] sum_q, lim_q, cand_q, next_c;
	logic                        hit_c, hit_q, ended_q;
	logic [PH_BITS-1:0]          clamp_c;
	logic                        loop_wrap, loop_reflect, loop_plain, loop_bad;

	// sample arithmetic
	logic signed [SMP_BITS-1:0]   s1_q, s0_q, interp_q;
	logic signed [DIFF_BITS-1:0]  d_q;
	logic signed [MUL_A_BITS-1:0] mul_a;
	logic signed [MUL_B_BITS-1:0] mul_b;
	logic signed [MUL_P_BITS-1:0] p_q;
	logic [IQ_BITS-1:0]           iq_c;
	logic [MUL_P_BITS-1:0]        rnd_c;
	logic signed [VAL_BITS-1:0]   val_c;
	logic signed [SMP_BITS-1:0]   sat_c;
	logic                         end_now;

	logic                        result_valid_q;
	logic signed [SMP_BITS-1:0]  sample_out_q;
	logic                        voice_active_q;

	assign result_valid = result_valid_q;
	assign sample_out   = sample_out_q;
	assign voice_active = voice_active_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			load_address_q <= load_address;
			load_data_q    <= load_data;
			sustain_q      <= sustain_held;
			envelope_q     <= envelope;
			env_idle_q     <= envelope_idle;
		end
	end

	assign idx       = phase_q[PH_BITS-1:FRAC_BITS];
	assign frac      = phase_q[FRAC_BITS-1:0];
	assign idx_lo    = (idx == '0) ? '0 : idx - IDX_BITS'(1);
	assign tick_skip = !playing_q || (idx >= cfg.sample_length);

	assign mem_addr = ctl.mem_we ? ADDR_BITS'(load_address_q) :
		(ctl.rd_lo ? ADDR_BITS'(idx_lo) : ADDR_BITS'(idx));

	wtlp_sample_ram #(
		.ADDR_W(ADDR_BITS),
		.DATA_W(SMP_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ctl.mem_we),
		.addr  (mem_addr),
		.wdata (load_data_q),
		.rdata (mem_rdata)
	);

	// phase in a wide signed frame
	assign ph_w  = $signed({{(WIDE_BITS-PH_BITS){1'b0}}, phase_q});
	assign inc_w = $signed({{(WIDE_BITS-INC_BITS){1'b0}}, cfg.phase_increment});
	assign ls_w  = $signed({{(WIDE_BITS-LS_BITS-FRAC_BITS){1'b0}}, cfg.loop_start,
		{FRAC_BITS{1'b0}}});
	assign le_w  = $signed({{(WIDE_BITS-LEN_BITS-FRAC_BITS){1'b0}}, cfg.loop_end,
		{FRAC_BITS{1'b0}}});
	assign len_w = $signed({{(WIDE_BITS-LEN_BITS-FRAC_BITS){1'b0}}, cfg.sample_length,
		{FRAC_BITS{1'b0}}});

	assign loop_reflect = (alm_q == LOOP_PINGPONG);
	assign loop_wrap    = (alm_q == LOOP_FORWARD) || (alm_q == LOOP_SUSTAIN && key_q);
	assign loop_plain   = !loop_reflect && !loop_wrap;
	assign loop_bad     = (cfg.loop_end <= {{(LEN_BITS-LS_BITS){1'b0}}, cfg.loop_start}) ||
		(cfg.loop_end > cfg.sample_length);

	always_comb begin
		if (loop_reflect) begin
			hit_c = fwd_q ? (sum_q >= le_w) : (sum_q <= ls_w);
		end else if (loop_wrap) begin
			hit_c = (sum_q >= le_w);
		end else begin
			hit_c = (sum_q >= len_w);
		end
	end

	assign next_c = (hit_q && !loop_plain) ? cand_q : sum_q;

	always_comb begin
		if (next_c[WIDE_BITS-1]) begin
			clamp_c = '0;
		end else if (|next_c[WIDE_BITS-2:PH_BITS]) begin
			clamp_c = '1;
		end else begin
			clamp_c = next_c[PH_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ph_sum) begin
			sum_q <= (loop_reflect && !fwd_q) ? ph_w - inc_w : ph_w + inc_w;
		end
		if (ctl.ph_lim) begin
			lim_q <= loop_reflect ? (fwd_q ? le_w <<< 1 : ls_w <<< 1) : le_w - ls_w;
		end
		if (ctl.ph_cmp) begin
			cand_q <= loop_reflect ? lim_q - sum_q : sum_q - lim_q;
			hit_q  <= hit_c;
		end
		if (ctl.ph_commit) begin
			ended_q <= loop_plain && hit_q;
		end
	end

	assign end_now = ctl.emit_zero || (ctl.emit && (ended_q || env_idle_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			fwd_q     <= 1'b1;
			key_q     <= 1'b0;
			playing_q <= 1'b0;
			alm_q     <= LOOP_NONE;
		end else begin
			if (ctl.note_on) begin
				phase_q   <= PH_ONE;
				fwd_q     <= 1'b1;
				key_q     <= 1'b1;
				playing_q <= 1'b1;
				alm_q     <= loop_bad ? LOOP_NONE : cfg.loop_mode;
			end
			if (ctl.note_off && !sustain_q) begin
				key_q <= 1'b0;
			end
			if (ctl.ph_commit) begin
				phase_q <= clamp_c;
				// released sustain loop falls back to one-shot
				if (alm_q == LOOP_SUSTAIN && !key_q) begin
					alm_q <= LOOP_NONE;
				end
				if (loop_reflect && hit_q) begin
					fwd_q <= !fwd_q;
				end
			end
			if (end_now) begin
				playing_q <= 1'b0;
			end
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (ctl.mul)
			MUL_FRAC_DIFF: begin
				mul_a = $signed({{(MUL_A_BITS-FRAC_BITS){1'b0}}, frac});
				mul_b = d_q;
			end
			MUL_INTERP_GAIN: begin
				mul_a = $signed({{(MUL_A_BITS-SMP_BITS){interp_q[SMP_BITS-1]}}, interp_q});
				mul_b = $signed({{(MUL_B_BITS-GAIN_BITS){1'b0}}, cfg.voice_gain});
			end
			MUL_PROD_ENV: begin
				mul_a = p_q[MUL_A_BITS-1:0];
				mul_b = $signed({{(MUL_B_BITS-ENV_BITS){1'b0}}, envelope_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign iq_c = {{2{s0_q[SMP_BITS-1]}}, s0_q, {FRAC_BITS{1'b0}}} +
		p_q[IQ_BITS-1:0] + IQ_HALF;

	assign rnd_c = p_q + OUT_ROUND;
	assign val_c = $signed(rnd_c[MUL_P_BITS-1:OUT_SHIFT]);

	always_comb begin
		if (val_c > SMP_MAX) begin
			sat_c = SMP_MAX;
		end else if (val_c < SMP_MIN) begin
			sat_c = SMP_MIN;
		end else begin
			sat_c = val_c[SMP_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_s1) begin
			s1_q <= $signed(mem_rdata);
		end
		if (ctl.cap_s0d) begin
			s0_q <= $signed(mem_rdata);
			d_q  <= $signed({s1_q[SMP_BITS-1], s1_q}) -
				$signed({mem_rdata[SMP_BITS-1], mem_rdata});
		end
		if (ctl.mul != MUL_NONE) begin
			p_q <= mul_a * mul_b;
		end
		if (ctl.interp) begin
			interp_q <= $signed(iq_c[FRAC_BITS+SMP_BITS-1:FRAC_BITS]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= ctl.emit || ctl.emit_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (end_now) begin
			sample_out_q   <= '0;
			voice_active_q <= 1'b0;
		end else if (ctl.emit) begin
			sample_out_q   <= sat_c;
			voice_active_q <= 1'b1;
		end
	end

	`WTLP_ASSERT_IMP(a_ended_zero, result_valid_q && !voice_active_q, sample_out_q == '0, "ended voice gives nonzero sample")
	`WTLP_ASSERT_NXT(a_single_strobe, result_valid_q, !result_valid_q, "result strobe longer than one cycle")
	`WTLP_ASSERT_NXT(a_note_on_plays, ctl.note_on, playing_q && key_q && fwd_q, "note on did not start voice")

endmodule
